### rtl/u2c_pkg.sv
// Shared constants and types for the UTF-8 to CP437 converter.
// Used by u2c_window, u2c_map and utf8_to_cp437_converter; no dependencies.

package u2c_pkg;

   // Number of pending bytes the decode window can hold (legal range 4 to 6).
   localparam int WINDOW_DEPTH = 4;
   localparam int COUNT_WIDTH  = $clog2(WINDOW_DEPTH + 1);

   // Widest code point that strict UTF-8 can carry.
   localparam int POINT_WIDTH  = 21;

   localparam logic [POINT_WIDTH-1:0] ASCII_TOP  = POINT_WIDTH'(32'h7F);
   localparam logic [7:0]             SUBST_CODE = 8'h3F;

   // Decoded character handed from the window stage to the mapping stage.
   typedef struct packed {
      logic                   valid;
      logic [POINT_WIDTH-1:0] point;
   } stage_type;

endpackage

### rtl/u2c_window.sv
// Byte window and strict UTF-8 decoder of the UTF-8 to CP437 converter.
// Holds the pending bytes and registers each decoded code point.
// Depends on u2c_pkg.

module u2c_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          in_byte,
   input  logic                stage_take,
   output u2c_pkg::stage_type  stage
);
   import u2c_pkg::*;

   logic [7:0]             window_ff [WINDOW_DEPTH];
   logic [7:0]             window_in [WINDOW_DEPTH];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] fill;
   logic                   full;
   logic                   req_fire;
   logic                   decode_ok;
   logic [POINT_WIDTH-1:0] point;
   logic                   pt_valid_ff;
   logic                   pt_valid_in;
   logic [POINT_WIDTH-1:0] point_ff;

   assign req_tready = !pt_valid_ff || stage_take;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == COUNT_WIDTH'(WINDOW_DEPTH));

   // Append the new byte; a full window first drops its oldest byte.
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
         if (full) begin
            window_in[i] = window_ff[i + 1];
         end else if (count_ff == COUNT_WIDTH'(i)) begin
            window_in[i] = in_byte;
         end else begin
            window_in[i] = window_ff[i];
         end
      end
      if (full || count_ff == COUNT_WIDTH'(WINDOW_DEPTH - 1)) begin
         window_in[WINDOW_DEPTH-1] = in_byte;
      end else begin
         window_in[WINDOW_DEPTH-1] = window_ff[WINDOW_DEPTH-1];
      end
      fill = full ? COUNT_WIDTH'(WINDOW_DEPTH) : count_ff + COUNT_WIDTH'(1);
   end

   // Strict decode of one character at the head of the updated window.
   always_comb begin
      logic [7:0] b0, b1, b2, b3;
      logic [7:0] lo2, hi2;
      logic [2:0] need;
      logic       lead_ok, c1_ok, c2_ok, c3_ok;
      b0      = window_in[0];
      b1      = window_in[1];
      b2      = window_in[2];
      b3      = window_in[3];
      lo2     = 8'h80;
      hi2     = 8'hBF;
      need    = 3'd1;
      lead_ok = 1'b1;
      point   = {14'd0, b0[6:0]};
      if (b0 <= 8'h7F) begin
         need = 3'd1;
      end else if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
         need  = 3'd2;
         point = {10'd0, b0[4:0], b1[5:0]};
      end else if (b0 >= 8'hE0 && b0 <= 8'hEF) begin
         need  = 3'd3;
         point = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         if (b0 == 8'hE0) lo2 = 8'hA0;
         if (b0 == 8'hED) hi2 = 8'h9F;
      end else if (b0 >= 8'hF0 && b0 <= 8'hF4) begin
         need  = 3'd4;
         point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
         if (b0 == 8'hF0) lo2 = 8'h90;
         if (b0 == 8'hF4) hi2 = 8'h8F;
      end else begin
         lead_ok = 1'b0;
      end
      c1_ok     = (need < 3'd2) || (b1 >= lo2 && b1 <= hi2);
      c2_ok     = (need < 3'd3) || (b2 >= 8'h80 && b2 <= 8'hBF);
      c3_ok     = (need < 3'd4) || (b3 >= 8'h80 && b3 <= 8'hBF);
      decode_ok = lead_ok && (fill >= COUNT_WIDTH'(need)) && c1_ok && c2_ok && c3_ok;
   end

   // A successful decode empties the window, trailing bytes included.
   assign count_in    = decode_ok ? '0 : fill;
   assign pt_valid_in = req_fire && decode_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         pt_valid_ff <= 1'b0;
      end else begin
         if (req_fire) count_ff <= count_in;
         if (req_tready) pt_valid_ff <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_ff <= window_in;
      end
      if (pt_valid_in) begin
         point_ff <= point;
      end
   end

   assign stage.valid = pt_valid_ff;
   assign stage.point = point_ff;

endmodule

### rtl/u2c_map.sv
// Code point to CP437 mapping stage and result register.
// Holds the fixed glyph table and drives the result channel.
// Depends on u2c_pkg.

module u2c_map (
   input  logic                clock,
   input  logic                reset,
   input  u2c_pkg::stage_type  stage,
   output logic                stage_take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          cp437_code,
   output logic                substituted
);
   import u2c_pkg::*;

   logic       rsp_valid_ff;
   logic [7:0] code_ff;
   logic [7:0] code_in;
   logic       subst_ff;
   logic       subst_in;

   // Returns zero for a code point without a glyph.
   function automatic logic [7:0] glyph(input logic [POINT_WIDTH-1:0] p);
      logic [7:0] g;
      case (p)
         21'hA0: g = 8'hFF;    21'hA1: g = 8'hAD;    21'hA2: g = 8'h9B;
         21'hA3: g = 8'h9C;    21'hA5: g = 8'h9D;    21'hA7: g = 8'h15;
         21'hAA: g = 8'hA6;    21'hAB: g = 8'hAE;    21'hAC: g = 8'hAA;
         21'hB0: g = 8'hF8;    21'hB1: g = 8'hF1;    21'hB2: g = 8'hFD;
         21'hB5: g = 8'hE6;    21'hB7: g = 8'hFA;    21'hBA: g = 8'hA7;
         21'hBB: g = 8'hAF;    21'hBC: g = 8'hAC;    21'hBD: g = 8'hAB;
         21'hBF: g = 8'hA8;    21'hC4: g = 8'h8E;    21'hC5: g = 8'h8F;
         21'hC6: g = 8'h92;    21'hC7: g = 8'h80;    21'hC9: g = 8'h90;
         21'hD1: g = 8'hA5;    21'hD6: g = 8'h99;    21'hDC: g = 8'h9A;
         21'hDF: g = 8'hE1;    21'hE0: g = 8'h85;    21'hE1: g = 8'hA0;
         21'hE2: g = 8'h83;    21'hE4: g = 8'h84;    21'hE5: g = 8'h86;
         21'hE6: g = 8'h91;    21'hE7: g = 8'h87;    21'hE8: g = 8'h8A;
         21'hE9: g = 8'h82;    21'hEA: g = 8'h88;    21'hEB: g = 8'h89;
         21'hEC: g = 8'h8D;    21'hED: g = 8'hA1;    21'hEE: g = 8'h8C;
         21'hEF: g = 8'h8B;    21'hF1: g = 8'hA4;    21'hF2: g = 8'h95;
         21'hF3: g = 8'hA2;    21'hF4: g = 8'h93;    21'hF6: g = 8'h94;
         21'hF7: g = 8'hF6;    21'hF9: g = 8'h97;    21'hFA: g = 8'hA3;
         21'hFB: g = 8'h96;    21'hFC: g = 8'h81;    21'hFD: g = 8'h79;
         21'hFF: g = 8'h98;    21'h192: g = 8'h9F;   21'h393: g = 8'hE2;
         21'h398: g = 8'hE9;   21'h3A3: g = 8'hE4;   21'h3A6: g = 8'hE8;
         21'h3A9: g = 8'hEA;   21'h3B1: g = 8'hE0;   21'h3B2: g = 8'hE1;
         21'h3B4: g = 8'hEB;   21'h3B5: g = 8'hEE;   21'h3C0: g = 8'hE3;
         21'h3C3: g = 8'hE5;   21'h3C4: g = 8'hE7;   21'h3C6: g = 8'hED;
         21'h2018: g = 8'h27;  21'h2019: g = 8'h27;  21'h201A: g = 8'h27;
         21'h201B: g = 8'h27;  21'h201C: g = 8'h22;  21'h201D: g = 8'h22;
         21'h201E: g = 8'h22;  21'h201F: g = 8'h22;  21'h2022: g = 8'h07;
         21'h203C: g = 8'h13;  21'h207F: g = 8'hFC;  21'h20A7: g = 8'h9E;
         21'h20AC: g = 8'hEE;  21'h2190: g = 8'h1B;  21'h2191: g = 8'h18;
         21'h2192: g = 8'h1A;  21'h2193: g = 8'h19;  21'h2194: g = 8'h1D;
         21'h2195: g = 8'h12;  21'h21A8: g = 8'h17;  21'h2219: g = 8'hF9;
         21'h221A: g = 8'hFB;  21'h221E: g = 8'hEC;  21'h221F: g = 8'h1C;
         21'h2229: g = 8'hEF;  21'h2248: g = 8'hF7;  21'h2261: g = 8'hF0;
         21'h2264: g = 8'hF3;  21'h2265: g = 8'hF2;  21'h2302: g = 8'h7F;
         21'h2310: g = 8'hA9;  21'h2320: g = 8'hF4;  21'h2321: g = 8'hF5;
         21'h2500: g = 8'hC4;  21'h2502: g = 8'hB3;  21'h250C: g = 8'hDA;
         21'h2510: g = 8'hBF;  21'h2514: g = 8'hC0;  21'h2518: g = 8'hD9;
         21'h251C: g = 8'hC3;  21'h2524: g = 8'hB4;  21'h252C: g = 8'hC2;
         21'h2534: g = 8'hC1;  21'h253C: g = 8'hC5;  21'h2550: g = 8'hCD;
         21'h2551: g = 8'hBA;  21'h2552: g = 8'hD5;  21'h2553: g = 8'hD6;
         21'h2554: g = 8'hC9;  21'h2555: g = 8'hB8;  21'h2556: g = 8'hB7;
         21'h2557: g = 8'hBB;  21'h2558: g = 8'hD4;  21'h2559: g = 8'hD3;
         21'h255A: g = 8'hC8;  21'h255B: g = 8'hBE;  21'h255C: g = 8'hBD;
         21'h255D: g = 8'hBC;  21'h255E: g = 8'hC6;  21'h255F: g = 8'hC7;
         21'h2560: g = 8'hCC;  21'h2561: g = 8'hB5;  21'h2562: g = 8'hB6;
         21'h2563: g = 8'hB9;  21'h2564: g = 8'hD1;  21'h2565: g = 8'hD2;
         21'h2566: g = 8'hCB;  21'h2567: g = 8'hCF;  21'h2568: g = 8'hD0;
         21'h2569: g = 8'hCA;  21'h256A: g = 8'hD8;  21'h256B: g = 8'hD7;
         21'h256C: g = 8'hCE;  21'h2580: g = 8'hDF;  21'h2584: g = 8'hDC;
         21'h2588: g = 8'hDB;  21'h258C: g = 8'hDD;  21'h2590: g = 8'hDE;
         21'h2591: g = 8'hB0;  21'h2592: g = 8'hB1;  21'h2593: g = 8'hB2;
         21'h25A0: g = 8'hFE;  21'h25AC: g = 8'h16;  21'h25B2: g = 8'h1E;
         21'h25BA: g = 8'h10;  21'h25BC: g = 8'h1F;  21'h25C4: g = 8'h11;
         21'h25CB: g = 8'h09;  21'h25D8: g = 8'h08;  21'h25D9: g = 8'h0A;
         21'h263A: g = 8'h01;  21'h263B: g = 8'h02;  21'h263C: g = 8'h0F;
         21'h2640: g = 8'h0C;  21'h2642: g = 8'h0B;  21'h2660: g = 8'h06;
         21'h2663: g = 8'h05;  21'h2665: g = 8'h03;  21'h2666: g = 8'h04;
         21'h266A: g = 8'h0D;  21'h266B: g = 8'h0E;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

   assign stage_take = !rsp_valid_ff || rsp_tready;

   // ASCII passes through; a zero code point or a missing glyph becomes '?'.
   always_comb begin
      logic [7:0] g;
      if (stage.point <= ASCII_TOP) begin
         g = stage.point[7:0];
      end else begin
         g = glyph(stage.point);
      end
      subst_in = (g == 8'h00);
      code_in  = subst_in ? SUBST_CODE : g;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_take) begin
         rsp_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take && stage.valid) begin
         code_ff  <= code_in;
         subst_ff <= subst_in;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign cp437_code  = code_ff;
   assign substituted = subst_ff;

endmodule

### rtl/utf8_to_cp437_converter.sv
// Top level of the UTF-8 to CP437 converter: window/decoder stage and mapping stage.
// Depends on u2c_pkg, u2c_window and u2c_map.
//
//   Channel   Direction  Ports        Contents
//   req       in         req_t*       one raw byte of the UTF-8 stream per transfer
//   rsp       out        rsp_t*       one CP437 character per decoded UTF-8 character
//
// Each transfer on req is handled in a single pass: the byte enters the window, the
// window head is checked and decoded, and the code point is registered in the same
// cycle; from that register the glyph table lookup fills the result register once it
// is free or rsp takes its result. The block takes one byte every cycle unless both
// stages hold a character and rsp stalls. Reset empties the window and both stages. When
// rsp stalls, the result register holds and the decode stage still takes bytes until it
// holds a character of its own.

module utf8_to_cp437_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] cp437_code
   output logic       rsp_tuser    // [0] substituted
);
   import u2c_pkg::*;

   stage_type stage;
   logic      stage_take;

   // Window, strict decode and the code point register.
   u2c_window u_window (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_byte    (req_tdata),
      .stage_take (stage_take),
      .stage      (stage)
   );

   // Glyph lookup and the result register that drives rsp.
   u2c_map u_map (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .stage_take  (stage_take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cp437_code  (rsp_tdata),
      .substituted (rsp_tuser)
   );

`ifndef SYNTH
   // The input side only waits when both stages hold a character and rsp stalls.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (stage.valid && rsp_tvalid && !rsp_tready))
      else $error("req_tready low while the pipeline has room");

   // A decoded character that cannot move on stays put.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !stage_take) |=> (stage.valid && $stable(stage.point)))
      else $error("decoded character lost or changed while stalled");

   // A substituted result always carries the question mark.
   a_subst_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == SUBST_CODE))
      else $error("substituted result without the replacement code");
`endif

endmodule

### test/utf8_to_cp437_converter_check.sv
// Scoreboard for the UTF-8 to CP437 converter: watches both stream channels, predicts the
// decoded characters and compares them against the result channel. Depends on u2c_pkg.

module utf8_to_cp437_converter_check
   import u2c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   output int         mismatch_count,
   output int         awaited_count,
   output int         glyph_count,
   output int         subst_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] code;
      logic       substituted;
   } glyph_type;

   logic [7:0] pending_bytes [WINDOW_DEPTH];
   int         pending_fill;
   glyph_type  awaited_glyphs [$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Glyph table lookup. Zero means the code point has no CP437 glyph.
   function automatic logic [7:0] cp437_of(input logic [POINT_WIDTH-1:0] cp);
      logic [7:0] glyph;
      if (cp <= ASCII_TOP) begin
         return cp[7:0];
      end
      case (cp)
         21'h0A0: glyph = 8'hFF;  21'h0A1: glyph = 8'hAD;  21'h0A2: glyph = 8'h9B;
         21'h0A3: glyph = 8'h9C;  21'h0A5: glyph = 8'h9D;  21'h0A7: glyph = 8'h15;
         21'h0AA: glyph = 8'hA6;  21'h0AB: glyph = 8'hAE;  21'h0AC: glyph = 8'hAA;
         21'h0B0: glyph = 8'hF8;  21'h0B1: glyph = 8'hF1;  21'h0B2: glyph = 8'hFD;
         21'h0B5: glyph = 8'hE6;  21'h0B7: glyph = 8'hFA;  21'h0BA: glyph = 8'hA7;
         21'h0BB: glyph = 8'hAF;  21'h0BC: glyph = 8'hAC;  21'h0BD: glyph = 8'hAB;
         21'h0BF: glyph = 8'hA8;  21'h0C4: glyph = 8'h8E;  21'h0C5: glyph = 8'h8F;
         21'h0C6: glyph = 8'h92;  21'h0C7: glyph = 8'h80;  21'h0C9: glyph = 8'h90;
         21'h0D1: glyph = 8'hA5;  21'h0D6: glyph = 8'h99;  21'h0DC: glyph = 8'h9A;
         21'h0DF: glyph = 8'hE1;  21'h0E0: glyph = 8'h85;  21'h0E1: glyph = 8'hA0;
         21'h0E2: glyph = 8'h83;  21'h0E4: glyph = 8'h84;  21'h0E5: glyph = 8'h86;
         21'h0E6: glyph = 8'h91;  21'h0E7: glyph = 8'h87;  21'h0E8: glyph = 8'h8A;
         21'h0E9: glyph = 8'h82;  21'h0EA: glyph = 8'h88;  21'h0EB: glyph = 8'h89;
         21'h0EC: glyph = 8'h8D;  21'h0ED: glyph = 8'hA1;  21'h0EE: glyph = 8'h8C;
         21'h0EF: glyph = 8'h8B;  21'h0F1: glyph = 8'hA4;  21'h0F2: glyph = 8'h95;
         21'h0F3: glyph = 8'hA2;  21'h0F4: glyph = 8'h93;  21'h0F6: glyph = 8'h94;
         21'h0F7: glyph = 8'hF6;  21'h0F9: glyph = 8'h97;  21'h0FA: glyph = 8'hA3;
         21'h0FB: glyph = 8'h96;  21'h0FC: glyph = 8'h81;  21'h0FD: glyph = 8'h79;
         21'h0FF: glyph = 8'h98;  21'h192: glyph = 8'h9F;  21'h393: glyph = 8'hE2;
         21'h398: glyph = 8'hE9;  21'h3A3: glyph = 8'hE4;  21'h3A6: glyph = 8'hE8;
         21'h3A9: glyph = 8'hEA;  21'h3B1: glyph = 8'hE0;  21'h3B2: glyph = 8'hE1;
         21'h3B4: glyph = 8'hEB;  21'h3B5: glyph = 8'hEE;  21'h3C0: glyph = 8'hE3;
         21'h3C3: glyph = 8'hE5;  21'h3C4: glyph = 8'hE7;  21'h3C6: glyph = 8'hED;
         21'h2018, 21'h2019, 21'h201A, 21'h201B: glyph = 8'h27;
         21'h201C, 21'h201D, 21'h201E, 21'h201F: glyph = 8'h22;
         21'h2022: glyph = 8'h07; 21'h203C: glyph = 8'h13; 21'h207F: glyph = 8'hFC;
         21'h20A7: glyph = 8'h9E; 21'h20AC: glyph = 8'hEE; 21'h2190: glyph = 8'h1B;
         21'h2191: glyph = 8'h18; 21'h2192: glyph = 8'h1A; 21'h2193: glyph = 8'h19;
         21'h2194: glyph = 8'h1D; 21'h2195: glyph = 8'h12; 21'h21A8: glyph = 8'h17;
         21'h2219: glyph = 8'hF9; 21'h221A: glyph = 8'hFB; 21'h221E: glyph = 8'hEC;
         21'h221F: glyph = 8'h1C; 21'h2229: glyph = 8'hEF; 21'h2248: glyph = 8'hF7;
         21'h2261: glyph = 8'hF0; 21'h2264: glyph = 8'hF3; 21'h2265: glyph = 8'hF2;
         21'h2302: glyph = 8'h7F; 21'h2310: glyph = 8'hA9; 21'h2320: glyph = 8'hF4;
         21'h2321: glyph = 8'hF5; 21'h2500: glyph = 8'hC4; 21'h2502: glyph = 8'hB3;
         21'h250C: glyph = 8'hDA; 21'h2510: glyph = 8'hBF; 21'h2514: glyph = 8'hC0;
         21'h2518: glyph = 8'hD9; 21'h251C: glyph = 8'hC3; 21'h2524: glyph = 8'hB4;
         21'h252C: glyph = 8'hC2; 21'h2534: glyph = 8'hC1; 21'h253C: glyph = 8'hC5;
         21'h2550: glyph = 8'hCD; 21'h2551: glyph = 8'hBA; 21'h2552: glyph = 8'hD5;
         21'h2553: glyph = 8'hD6; 21'h2554: glyph = 8'hC9; 21'h2555: glyph = 8'hB8;
         21'h2556: glyph = 8'hB7; 21'h2557: glyph = 8'hBB; 21'h2558: glyph = 8'hD4;
         21'h2559: glyph = 8'hD3; 21'h255A: glyph = 8'hC8; 21'h255B: glyph = 8'hBE;
         21'h255C: glyph = 8'hBD; 21'h255D: glyph = 8'hBC; 21'h255E: glyph = 8'hC6;
         21'h255F: glyph = 8'hC7; 21'h2560: glyph = 8'hCC; 21'h2561: glyph = 8'hB5;
         21'h2562: glyph = 8'hB6; 21'h2563: glyph = 8'hB9; 21'h2564: glyph = 8'hD1;
         21'h2565: glyph = 8'hD2; 21'h2566: glyph = 8'hCB; 21'h2567: glyph = 8'hCF;
         21'h2568: glyph = 8'hD0; 21'h2569: glyph = 8'hCA; 21'h256A: glyph = 8'hD8;
         21'h256B: glyph = 8'hD7; 21'h256C: glyph = 8'hCE; 21'h2580: glyph = 8'hDF;
         21'h2584: glyph = 8'hDC; 21'h2588: glyph = 8'hDB; 21'h258C: glyph = 8'hDD;
         21'h2590: glyph = 8'hDE; 21'h2591: glyph = 8'hB0; 21'h2592: glyph = 8'hB1;
         21'h2593: glyph = 8'hB2; 21'h25A0: glyph = 8'hFE; 21'h25AC: glyph = 8'h16;
         21'h25B2: glyph = 8'h1E; 21'h25BA: glyph = 8'h10; 21'h25BC: glyph = 8'h1F;
         21'h25C4: glyph = 8'h11; 21'h25CB: glyph = 8'h09; 21'h25D8: glyph = 8'h08;
         21'h25D9: glyph = 8'h0A; 21'h263A: glyph = 8'h01; 21'h263B: glyph = 8'h02;
         21'h263C: glyph = 8'h0F; 21'h2640: glyph = 8'h0C; 21'h2642: glyph = 8'h0B;
         21'h2660: glyph = 8'h06; 21'h2663: glyph = 8'h05; 21'h2665: glyph = 8'h03;
         21'h2666: glyph = 8'h04; 21'h266A: glyph = 8'h0D; 21'h266B: glyph = 8'h0E;
         default: glyph = 8'h00;
      endcase
      return glyph;
   endfunction

   // Strict decode of one character at the head of the pending bytes.
   function automatic bit decode_head(output logic [POINT_WIDTH-1:0] cp);
      logic [7:0]             lead;
      logic [7:0]             low_second;
      logic [7:0]             high_second;
      logic [7:0]             lo;
      logic [7:0]             hi;
      logic [POINT_WIDTH-1:0] acc;
      int                     need;
      lead        = pending_bytes[0];
      low_second  = 8'h80;
      high_second = 8'hBF;
      cp          = '0;
      if (pending_fill == 0) begin
         return 1'b0;
      end
      if (lead <= 8'h7F) begin
         cp = POINT_WIDTH'(lead);
         return 1'b1;
      end else if (lead >= 8'hC2 && lead <= 8'hDF) begin
         need = 2;
         acc  = POINT_WIDTH'(lead[4:0]);
      end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
         need = 3;
         acc  = POINT_WIDTH'(lead[3:0]);
         if (lead == 8'hE0) low_second = 8'hA0;
         if (lead == 8'hED) high_second = 8'h9F;
      end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
         need = 4;
         acc  = POINT_WIDTH'(lead[2:0]);
         if (lead == 8'hF0) low_second = 8'h90;
         if (lead == 8'hF4) high_second = 8'h8F;
      end else begin
         return 1'b0;
      end
      if (pending_fill < need || need > WINDOW_DEPTH) begin
         return 1'b0;
      end
      for (int i = 1; i < need; i++) begin
         lo = (i == 1) ? low_second : 8'h80;
         hi = (i == 1) ? high_second : 8'hBF;
         if (pending_bytes[i] < lo || pending_bytes[i] > hi) begin
            return 1'b0;
         end
         acc = (acc << 6) | POINT_WIDTH'(pending_bytes[i][5:0]);
      end
      cp = acc;
      return 1'b1;
   endfunction

   // One accepted byte: shift the window if full, append, try a decode.
   task automatic absorb_byte(input logic [7:0] data);
      logic [POINT_WIDTH-1:0] cp;
      logic [7:0]             glyph;
      if (pending_fill >= WINDOW_DEPTH) begin
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            pending_bytes[i] = pending_bytes[i + 1];
         end
         pending_fill = WINDOW_DEPTH - 1;
      end
      pending_bytes[pending_fill] = data;
      pending_fill++;
      if (decode_head(cp)) begin
         pending_fill = 0;
         glyph = cp437_of(cp);
         if (glyph == 8'h00) begin
            awaited_glyphs.push_back('{code: SUBST_CODE, substituted: 1'b1});
         end else begin
            awaited_glyphs.push_back('{code: glyph, substituted: 1'b0});
         end
      end
   endtask

   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         pending_fill = 0;
         awaited_glyphs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            glyph_count++;
            if (rsp_tuser) subst_count++;
            if (awaited_glyphs.size() == 0) begin
               report_mismatch($sformatf("unexpected result code %02h substituted %0b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = awaited_glyphs.pop_front();
               if (rsp_tdata !== want.code)
                  report_mismatch($sformatf("cp437_code %02h, expected %02h",
                                            rsp_tdata, want.code));
               if (rsp_tuser !== want.substituted)
                  report_mismatch($sformatf("substituted %0b, expected %0b (code %02h)",
                                            rsp_tuser, want.substituted, want.code));
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata);
         end
      end
      awaited_count = awaited_glyphs.size();
   end

endmodule

### test/utf8_to_cp437_converter_test.sv
// Top of the UTF-8 to CP437 converter testbench: clock, reset, byte stimulus and verdict.
// Depends on u2c_pkg, utf8_to_cp437_converter and utf8_to_cp437_converter_check.

module utf8_to_cp437_converter_test;

   timeunit 1ns;
   timeprecision 1ps;

   import u2c_pkg::*;

   // Number of random bytes after the directed opening.
   localparam int RANDOM_BYTES = 1500;
   // The final stretch of the run runs with both sides at full rate.
   localparam int CALM_BYTES   = 200;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;

   int mismatch_count;
   int awaited_count;
   int glyph_count;
   int subst_count;

   int bytes_sent;
   // Chance in percent that a byte is preceded by an idle burst on req, and
   // that a stall burst is inserted on rsp.
   int gap_percent;
   int stall_percent;

   // Directed opening: zero code point, a genuine question mark, the top of
   // ASCII, two-, three- and four-byte characters (mapped and unmapped), the
   // highest legal code point, and an invalid lead byte that only leaves the
   // window by shifting, after which the head decodes and the bytes behind it
   // are thrown away.
   logic [7:0] opening_bytes [$] = {
      8'h00, 8'h3F, 8'h7F,
      8'hC3, 8'hA9,
      8'hE2, 8'h82, 8'hAC,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hC2, 8'h80,
      8'hF4, 8'h8F, 8'hBF, 8'hBF,
      8'hFF, 8'h41, 8'h41, 8'h41, 8'h42
   };

   utf8_to_cp437_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   utf8_to_cp437_converter_check check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .glyph_count    (glyph_count),
      .subst_count    (subst_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hands one byte to the converter. An optional idle burst goes first; valid
   // is only lowered for such a burst, so back-to-back transfers keep it high.
   task automatic send_byte(input logic [7:0] data);
      if (gap_percent > 0 && $urandom_range(1, 100) <= gap_percent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Picks a code point from one of several regions. Most regions are dense
   // in glyph table entries; the rest span the whole three- and four-byte ranges so
   // unmapped points and the length boundaries of those encodings are reached too.
   function automatic logic [POINT_WIDTH-1:0] pick_point();
      int unsigned cp;
      case ($urandom_range(0, 7))
         0: cp = $urandom_range(32'h00, 32'h7F);
         1: cp = $urandom_range(32'h80, 32'hFF);
         2: cp = $urandom_range(32'h380, 32'h3CF);
         3: cp = $urandom_range(32'h2010, 32'h20AF);
         4: cp = $urandom_range(32'h2190, 32'h2321);
         5: cp = $urandom_range(32'h2500, 32'h266F);
         6: begin
            // Three-byte range without the surrogate block.
            cp = $urandom_range(32'h800, 32'hF7FF);
            if (cp >= 32'hD800) cp += 32'h800;
         end
         default: cp = $urandom_range(32'h10000, 32'h10FFFF);
      endcase
      return POINT_WIDTH'(cp);
   endfunction

   // Encodes a code point as UTF-8 and sends it. A truncated character loses
   // its last byte; a corrupted one has one continuation byte replaced with a
   // random byte.
   task automatic send_point(input logic [POINT_WIDTH-1:0] cp, input bit truncate,
                             input bit corrupt);
      logic [7:0] seq [4];
      int         len;
      if (cp < 21'h80) begin
         seq[0] = cp[7:0];
         len = 1;
      end else if (cp < 21'h800) begin
         seq[0] = {3'b110, cp[10:6]};
         seq[1] = {2'b10, cp[5:0]};
         len = 2;
      end else if (cp < 21'h10000) begin
         seq[0] = {4'b1110, cp[15:12]};
         seq[1] = {2'b10, cp[11:6]};
         seq[2] = {2'b10, cp[5:0]};
         len = 3;
      end else begin
         seq[0] = {5'b11110, cp[20:18]};
         seq[1] = {2'b10, cp[17:12]};
         seq[2] = {2'b10, cp[11:6]};
         seq[3] = {2'b10, cp[5:0]};
         len = 4;
      end
      if (corrupt && len > 1) seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      if (truncate && len > 1) len--;
      for (int i = 0; i < len; i++) send_byte(seq[i]);
   endtask

   // Result side: ready stays high for random stretches and drops for stall
   // bursts whenever stall_percent allows.
   initial begin
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (stall_percent > 0 && $urandom_range(1, 100) <= stall_percent) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int next_shuffle;
      int kind;
      bytes_sent    = 0;
      gap_percent   = 25;
      stall_percent = 30;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      // Random part. Every so often the idle and stall rates are redrawn so
      // that quiet stretches alternate with heavy back pressure; the last
      // stretch runs with none.
      next_shuffle = bytes_sent;
      while (bytes_sent < opening_bytes.size() + RANDOM_BYTES) begin
         if (bytes_sent >= opening_bytes.size() + RANDOM_BYTES - CALM_BYTES) begin
            gap_percent   = 0;
            stall_percent = 0;
         end else if (bytes_sent >= next_shuffle) begin
            next_shuffle  = bytes_sent + 120;
            gap_percent   = $urandom_range(0, 2) * 25;
            stall_percent = $urandom_range(0, 2) * 30;
         end
         // Mostly well-formed characters, with some truncated or corrupted
         // ones and raw noise bytes in between.
         kind = $urandom_range(1, 100);
         if (kind <= 75)      send_point(pick_point(), 1'b0, 1'b0);
         else if (kind <= 85) send_point(pick_point(), 1'b1, 1'b0);
         else if (kind <= 92) send_point(pick_point(), 1'b0, 1'b1);
         else                 send_byte(8'($urandom_range(0, 255)));
      end
      req_tvalid <= 1'b0;

      // Drain, then keep waiting for any stray result to leave both stages.
      while (awaited_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Summary: %0d bytes sent (%0d directed), %0d characters received,",
               bytes_sent, opening_bytes.size(), glyph_count);
      $display("Summary: %0d of them substituted, %0d mismatches.",
               subst_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("utf8_to_cp437_converter verification clean");
      end else begin
         $display("utf8_to_cp437_converter verification failed");
      end
      $finish;
   end

   // Watchdog: the slowest correct run needs no more than about a tenth of this.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still awaited.", awaited_count);
      $display("utf8_to_cp437_converter verification failed");
      $finish;
   end

endmodule
